// ===== hw/rtl/stream_find_replace_top_assert.svh =====
// assertion macros used by the checker file
`ifndef STREAM_FIND_REPLACE_TOP_ASSERT_SVH
`define STREAM_FIND_REPLACE_TOP_ASSERT_SVH

// clocked check, held off while in reset
`define SFR_CHECK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// a stalled output beat keeps its valid and the given payload signal
`define SFR_CHECK_HOLD(label, sig, msg) \
    `SFR_CHECK(label, out_valid && out_stall |=> out_valid && $stable(sig), msg)

`endif

// ===== hw/rtl/sfr_pkg.sv =====
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types and constants of the stream find-and-replace block.
// ----------------------------------------------------------------------------
package sfr_pkg;

    // usable pattern and replacement lengths
    localparam int MAX_PATTERN_BYTES     = 8;
    localparam int MAX_REPLACEMENT_BYTES = 8;
    localparam int PAT_LIMIT = (MAX_PATTERN_BYTES < 8) ? MAX_PATTERN_BYTES : 8;
    localparam int REP_LIMIT = (MAX_REPLACEMENT_BYTES < 8) ? MAX_REPLACEMENT_BYTES : 8;

    // window and beat-group geometry
    localparam int WIN_DEPTH   = 8;
    localparam int WIN_IDX_W   = $clog2(WIN_DEPTH);
    localparam int FILL_W      = $clog2(WIN_DEPTH + 1);
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_INDEX_W = 3;
    localparam int LEN_W       = 4;

    // decoupling queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PATTERN_BYTES      = 3'd0,
        REG_PATTERN_LENGTH     = 3'd1,
        REG_REPLACEMENT_BYTES  = 3'd2,
        REG_REPLACEMENT_LENGTH = 3'd3,
        REG_REPLACE_ALL_MODE   = 3'd4
    } cfg_reg_t;

    // group of output beats produced by one input byte
    typedef struct packed {
        logic [WIN_DEPTH-1:0][7:0] bytes;
        logic [FILL_W-1:0]         count;
        logic                      last;
    } entry_t;

    // queue status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// ===== hw/rtl/stream_find_replace_top.sv =====
// ----------------------------------------------------------------------------
// stream_find_replace_top
// Streaming find-and-replace over a byte stream with a last-byte flag.
// ----------------------------------------------------------------------------
// One text byte enters per cycle; each byte yields zero or more output beats
// (the oldest unmatched byte, the replacement on a match, or the window flush
// on the final byte, which also carries the end flag). The front accepts and
// matches a byte every cycle as long as its two-entry queue has room; the
// back serializer sends one beat per cycle unless out_stall is high, and the
// input stalls once the queue fills behind a byte of many beats. Sustained
// rate is one byte per cycle while bytes map one to one and nothing stalls;
// a byte is registered in the queue and then at the output. Configuration is
// taken on any cycle (ready is always high) and applies to the next byte.
// ----------------------------------------------------------------------------
module stream_find_replace_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [7:0]                      text_byte,
    input  logic                            end_of_text,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [7:0]                      out_byte,
    output logic                            byte_present,
    output logic                            end_of_output,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [sfr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [sfr_pkg::CFG_DATA_W-1:0]  cfg_data
);

    logic                push;
    logic                pop;
    sfr_pkg::entry_t     push_entry;
    sfr_pkg::entry_t     head;
    sfr_pkg::q_status_t  q_status;

    // window, matching and configuration
    sfr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .text_byte  (text_byte),
        .end_of_text(end_of_text),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .q_status   (q_status),
        .push       (push),
        .push_entry (push_entry)
    );

    // beat groups waiting for the serializer
    sfr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .status     (q_status)
    );

    // output serializer
    sfr_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .q_status     (q_status),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_byte     (out_byte),
        .byte_present (byte_present),
        .end_of_output(end_of_output)
    );

endmodule

// ===== hw/rtl/sfr_front.sv =====
// ----------------------------------------------------------------------------
// sfr_front
// Holds the configuration and the window of unmatched bytes, matches each
// incoming byte and pushes the resulting group of output bytes to the queue.
// ----------------------------------------------------------------------------
module sfr_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [7:0]                          text_byte,
    input  logic                                end_of_text,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sfr_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [sfr_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  sfr_pkg::q_status_t                  q_status,
    output logic                                push,
    output sfr_pkg::entry_t                     push_entry
);

    logic [sfr_pkg::CFG_DATA_W-1:0] pattern_reg;
    logic [sfr_pkg::LEN_W-1:0]      pat_len_reg;
    logic [sfr_pkg::CFG_DATA_W-1:0] replacement_reg;
    logic [sfr_pkg::LEN_W-1:0]      rep_len_reg;
    logic                           replace_all_reg;

    logic [7:0]                  win_reg [sfr_pkg::WIN_DEPTH];
    logic [7:0]                  win_next [sfr_pkg::WIN_DEPTH];
    logic [7:0]                  win_app [sfr_pkg::WIN_DEPTH];
    logic [sfr_pkg::FILL_W-1:0]  fill_reg;
    logic [sfr_pkg::FILL_W-1:0]  fill_next;
    logic [sfr_pkg::FILL_W-1:0]  fill_app;
    logic                        replaced_reg;
    logic                        replaced_next;

    logic                        accept;
    logic                        room;
    logic [sfr_pkg::FILL_W-1:0]  plen;
    logic [sfr_pkg::FILL_W-1:0]  rlen;
    logic                        bytes_equal;
    logic                        at_len;
    logic                        over_len;
    logic                        hit;
    logic                        emit_old;
    logic [sfr_pkg::WIN_DEPTH-1:0][7:0] win_packed;

    assign cfg_ready = 1'b1;
    assign in_stall  = q_status.full;
    assign accept    = in_valid && !q_status.full;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg     <= '0;
            pat_len_reg     <= sfr_pkg::LEN_W'(1);
            replacement_reg <= '0;
            rep_len_reg     <= '0;
            replace_all_reg <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (sfr_pkg::cfg_reg_t'(cfg_index))
                sfr_pkg::REG_PATTERN_BYTES:      pattern_reg     <= cfg_data;
                sfr_pkg::REG_PATTERN_LENGTH:     pat_len_reg     <= cfg_data[sfr_pkg::LEN_W-1:0];
                sfr_pkg::REG_REPLACEMENT_BYTES:  replacement_reg <= cfg_data;
                sfr_pkg::REG_REPLACEMENT_LENGTH: rep_len_reg     <= cfg_data[sfr_pkg::LEN_W-1:0];
                sfr_pkg::REG_REPLACE_ALL_MODE:   replace_all_reg <= cfg_data[0];
                default:                         ;
            endcase
        end
    end

    // clamp the lengths to what the block supports
    always_comb
    begin
        if (pat_len_reg == '0)
            plen = sfr_pkg::FILL_W'(1);
        else if (pat_len_reg > sfr_pkg::LEN_W'(sfr_pkg::PAT_LIMIT))
            plen = sfr_pkg::FILL_W'(sfr_pkg::PAT_LIMIT);
        else
            plen = sfr_pkg::FILL_W'(pat_len_reg);

        if (rep_len_reg > sfr_pkg::LEN_W'(sfr_pkg::REP_LIMIT))
            rlen = sfr_pkg::FILL_W'(sfr_pkg::REP_LIMIT);
        else
            rlen = sfr_pkg::FILL_W'(rep_len_reg);
    end

    // window with the new byte appended
    assign room     = fill_reg < sfr_pkg::FILL_W'(sfr_pkg::WIN_DEPTH);
    assign fill_app = room ? fill_reg + sfr_pkg::FILL_W'(1) : fill_reg;

    always_comb
    begin
        for (int i = 0; i < sfr_pkg::WIN_DEPTH; i++)
        begin
            win_app[i]    = (room && fill_reg == sfr_pkg::FILL_W'(i)) ? text_byte : win_reg[i];
            win_packed[i] = win_app[i];
        end
    end

    // pattern compare over the used length
    always_comb
    begin
        bytes_equal = 1'b1;
        for (int i = 0; i < sfr_pkg::WIN_DEPTH; i++)
        begin
            if (sfr_pkg::FILL_W'(i) < plen && win_app[i] != pattern_reg[8*i +: 8])
                bytes_equal = 1'b0;
        end
    end

    assign at_len   = fill_app == plen;
    assign over_len = fill_app > plen;
    assign hit      = at_len && (replace_all_reg || !replaced_reg) && bytes_equal;
    assign emit_old = over_len || (at_len && !hit);

    // beat group for this byte: replacement, flush of window, or oldest byte
    always_comb
    begin
        push_entry.last = end_of_text;
        if (hit)
        begin
            push_entry.bytes = replacement_reg;
            push_entry.count = rlen;
        end
        else if (end_of_text)
        begin
            push_entry.bytes = win_packed;
            push_entry.count = fill_app;
        end
        else if (emit_old)
        begin
            push_entry.bytes = win_packed;
            push_entry.count = sfr_pkg::FILL_W'(1);
        end
        else
        begin
            push_entry.bytes = win_packed;
            push_entry.count = '0;
        end
    end

    assign push = accept && (push_entry.count != '0 || end_of_text);

    // next window state
    always_comb
    begin
        for (int i = 0; i < sfr_pkg::WIN_DEPTH; i++)
        begin
            if (emit_old && i < sfr_pkg::WIN_DEPTH - 1)
                win_next[i] = win_app[i + 1];
            else
                win_next[i] = win_app[i];
        end

        if (end_of_text)
        begin
            fill_next     = '0;
            replaced_next = 1'b0;
        end
        else if (hit)
        begin
            fill_next     = '0;
            replaced_next = 1'b1;
        end
        else if (emit_old)
        begin
            fill_next     = fill_app - sfr_pkg::FILL_W'(1);
            replaced_next = replaced_reg;
        end
        else
        begin
            fill_next     = fill_app;
            replaced_next = replaced_reg;
        end
    end

    // window control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg     <= '0;
            replaced_reg <= 1'b0;
        end
        else if (accept)
        begin
            fill_reg     <= fill_next;
            replaced_reg <= replaced_next;
        end
    end

    // window bytes
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < sfr_pkg::WIN_DEPTH; i++)
                win_reg[i] <= win_next[i];
        end
    end

endmodule

// ===== hw/rtl/sfr_queue.sv =====
// ----------------------------------------------------------------------------
// sfr_queue
// Short queue of beat groups between the matching front and the serializer.
// ----------------------------------------------------------------------------
module sfr_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  sfr_pkg::entry_t     push_entry,
    input  logic                pop,
    output sfr_pkg::entry_t     head,
    output sfr_pkg::q_status_t  status
);

    sfr_pkg::entry_t             mem_reg [sfr_pkg::QUEUE_DEPTH];
    logic [sfr_pkg::QPTR_W-1:0]  wr_ptr_reg;
    logic [sfr_pkg::QPTR_W-1:0]  wr_ptr_next;
    logic [sfr_pkg::QPTR_W-1:0]  rd_ptr_reg;
    logic [sfr_pkg::QPTR_W-1:0]  rd_ptr_next;
    logic [sfr_pkg::QCNT_W-1:0]  count_reg;
    logic [sfr_pkg::QCNT_W-1:0]  count_next;

    assign status.full  = count_reg == sfr_pkg::QCNT_W'(sfr_pkg::QUEUE_DEPTH);
    assign status.empty = count_reg == '0;
    assign head         = mem_reg[rd_ptr_reg];

    // pointer wrap and occupancy
    always_comb
    begin
        if (wr_ptr_reg == sfr_pkg::QPTR_W'(sfr_pkg::QUEUE_DEPTH - 1))
            wr_ptr_next = '0;
        else
            wr_ptr_next = wr_ptr_reg + sfr_pkg::QPTR_W'(1);

        if (rd_ptr_reg == sfr_pkg::QPTR_W'(sfr_pkg::QUEUE_DEPTH - 1))
            rd_ptr_next = '0;
        else
            rd_ptr_next = rd_ptr_reg + sfr_pkg::QPTR_W'(1);

        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + sfr_pkg::QCNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - sfr_pkg::QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_next;
            if (pop)
                rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

// ===== hw/rtl/sfr_back.sv =====
// ----------------------------------------------------------------------------
// sfr_back
// Serializes the queue head into output beats, one byte per cycle while the
// output is not stalled, through an output register.
// ----------------------------------------------------------------------------
module sfr_back (
    input  logic                clk,
    input  logic                rst_n,
    input  sfr_pkg::entry_t     head,
    input  sfr_pkg::q_status_t  q_status,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [7:0]          out_byte,
    output logic                byte_present,
    output logic                end_of_output
);

    logic [sfr_pkg::WIN_IDX_W-1:0] idx_reg;
    logic [sfr_pkg::WIN_IDX_W-1:0] idx_next;
    logic                          out_valid_reg;
    logic [7:0]                    out_byte_reg;
    logic                          present_reg;
    logic                          eoo_reg;
    logic                          load;
    logic                          head_done;

    // last beat of the head group (an empty end marker is one beat)
    assign head_done = (head.count == '0) ||
                       ({1'b0, idx_reg} + sfr_pkg::FILL_W'(1) == head.count);
    assign load      = !q_status.empty && (!out_valid_reg || !out_stall);
    assign pop       = load && head_done;
    assign idx_next  = head_done ? '0 : idx_reg + sfr_pkg::WIN_IDX_W'(1);

    // output valid and byte index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
            idx_reg       <= idx_next;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output beat payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg <= (head.count == '0) ? 8'd0 : head.bytes[idx_reg];
            present_reg  <= head.count != '0;
            eoo_reg      <= head.last && head_done;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_byte      = out_byte_reg;
    assign byte_present  = present_reg;
    assign end_of_output = eoo_reg;

endmodule

// ===== hw/rtl/sfr_checker.sv =====
// ----------------------------------------------------------------------------
// sfr_checker
// Port-level checks of the stream find-and-replace block, bound to the top.
// ----------------------------------------------------------------------------
`include "stream_find_replace_top_assert.svh"

module sfr_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_stall,
    input logic                            out_valid,
    input logic                            out_stall,
    input logic [7:0]                      out_byte,
    input logic                            byte_present,
    input logic                            end_of_output
);

    // stalled output beat holds
    `SFR_CHECK_HOLD(a_hold_byte, out_byte, "stalled out_byte changed")
    `SFR_CHECK_HOLD(a_hold_end, end_of_output, "stalled end_of_output changed")

    // an empty beat is only the end marker, with a zero byte
    `SFR_CHECK(a_empty_marker, out_valid && !byte_present |-> end_of_output && out_byte == 8'd0, "empty beat is not an end marker")

    // input only backs up behind a pending output beat
    `SFR_CHECK(a_stall_backed, in_stall |-> out_valid, "input stalled with no output beat pending")

endmodule

bind stream_find_replace_top sfr_checker u_sfr_checker (.*);

// ===== tb/sv/stream_find_replace_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stream_find_replace_top_tb
// Self-checking bench for the streaming find-and-replace block. Texts are
// driven one byte per beat. A local model of the match window predicts the
// rewritten beats, and every output beat is compared field by field. Idle
// gaps and stalls are inserted at random on both sides.
// ----------------------------------------------------------------------------
module stream_find_replace_top_tb;

    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 16;
    localparam int RANDOM_ITEMS  = 480;
    localparam int REPORT_LINES  = 40;
    localparam int RUN_LIMIT_NS  = 2_000_000;

    // one rewritten output beat
    typedef struct {
        logic [7:0] data;
        logic       present;
        logic       eot;
    } beat_t;

    // dut ports
    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_stall;
    logic [7:0]       text_byte = 8'h00;
    logic             end_of_text = 1'b0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    logic [7:0]       out_byte;
    logic             byte_present;
    logic             end_of_output;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    sfr_pkg::cfg_reg_t cfg_index = sfr_pkg::REG_PATTERN_BYTES;
    logic [sfr_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    // local copy of the registers, reset values
    logic [63:0] find_bytes  = 64'h0;
    logic [3:0]  find_len    = 4'd1;
    logic [63:0] subst_bytes = 64'h0;
    logic [3:0]  subst_len   = 4'd0;
    logic        all_mode    = 1'b1;

    // local copy of the match window
    logic [7:0] win_bytes [8];
    int         win_fill      = 0;
    logic       replaced_once = 1'b0;

    // beats of the rewritten text not yet seen at the output
    beat_t rewritten_beats[$];
    beat_t step_beats[$];
    beat_t seen_want;

    int send_idle_pct = 31;
    int recv_idle_pct = 45;
    int error_count   = 0;
    int beat_count    = 0;

    stream_find_replace_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .text_byte     (text_byte),
        .end_of_text   (end_of_text),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_byte      (out_byte),
        .byte_present  (byte_present),
        .end_of_output (end_of_output),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("stream_find_replace_top_tb: errors");
        $finish;
    end

    // lengths as the block applies them
    function automatic int find_len_used();
        int n;
        n = find_len;
        if (n == 0)
            n = 1;
        if (n > sfr_pkg::PAT_LIMIT)
            n = sfr_pkg::PAT_LIMIT;
        return n;
    endfunction

    function automatic int subst_len_used();
        int n;
        n = subst_len;
        if (n > sfr_pkg::REP_LIMIT)
            n = sfr_pkg::REP_LIMIT;
        return n;
    endfunction

    // queue one real byte for the current input beat, eight at most
    function automatic void add_text_beat(input logic [7:0] d);
        beat_t b;
        b.data = d;
        b.present = 1'b1;
        b.eot = 1'b0;
        if (step_beats.size() < 8)
            step_beats.push_back(b);
    endfunction

    // shift the window down by one byte
    function automatic void drop_oldest();
        int i;
        for (i = 0; i + 1 < win_fill && i + 1 < 8; i++)
            win_bytes[i] = win_bytes[i + 1];
        if (win_fill > 0)
            win_fill--;
    endfunction

    // advance the window by one text byte and queue the beats it yields
    task automatic rewrite_byte(input logic [7:0] b, input logic last);
        int    plen;
        int    i;
        logic  hit;
        beat_t marker;
        plen = find_len_used();
        step_beats.delete();
        if (win_fill < 8)
        begin
            win_bytes[win_fill] = b;
            win_fill++;
        end
        // window too long after a shorter pattern: pass the oldest byte only
        if (win_fill > plen)
        begin
            add_text_beat(win_bytes[0]);
            drop_oldest();
        end
        else if (win_fill == plen)
        begin
            hit = all_mode || !replaced_once;
            for (i = 0; i < plen; i++)
                if (win_bytes[i] != find_bytes[8*i +: 8])
                    hit = 1'b0;
            if (hit)
            begin
                for (i = 0; i < subst_len_used(); i++)
                    add_text_beat(subst_bytes[8*i +: 8]);
                win_fill = 0;
                replaced_once = 1'b1;
            end
            else
            begin
                add_text_beat(win_bytes[0]);
                drop_oldest();
            end
        end
        // final byte: flush the window and flag the last beat
        if (last)
        begin
            for (i = 0; i < win_fill && i < 8; i++)
                add_text_beat(win_bytes[i]);
            win_fill = 0;
            replaced_once = 1'b0;
            if (step_beats.size() == 0)
            begin
                marker.data = 8'h00;
                marker.present = 1'b0;
                marker.eot = 1'b1;
                step_beats.push_back(marker);
            end
            else
                step_beats[step_beats.size() - 1].eot = 1'b1;
        end
        foreach (step_beats[i])
            rewritten_beats.push_back(step_beats[i]);
    endtask

    // print one mismatch line and count it
    task automatic report_mismatch(input string field, input logic [7:0] got,
                                   input logic [7:0] want);
        error_count++;
        if (error_count <= REPORT_LINES)
            $display("%0t ns: output beat %0d: %s is %h, expected %h",
                     $time, beat_count, field, got, want);
    endtask

    // receiver stalls
    always @(posedge clk)
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);

    // output beat checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (rewritten_beats.size() == 0)
                report_mismatch("beat with none expected, out_byte", out_byte, 8'h00);
            else
            begin
                seen_want = rewritten_beats.pop_front();
                if (out_byte !== seen_want.data)
                    report_mismatch("out_byte", out_byte, seen_want.data);
                if (byte_present !== seen_want.present)
                    report_mismatch("byte_present", 8'(byte_present), 8'(seen_want.present));
                if (end_of_output !== seen_want.eot)
                    report_mismatch("end_of_output", 8'(end_of_output), 8'(seen_want.eot));
            end
            beat_count++;
        end
    end

    // send one text byte, valid is left high after the beat
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        text_byte   <= b;
        end_of_text <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        rewrite_byte(b, last);
    endtask

    task automatic send_string(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            send_byte(s[i], i == s.len() - 1);
    endtask

    // drop valid, drain all expected beats, let the pipeline empty
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (rewritten_beats.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // one register write, valid is left high after the beat
    task automatic cfg_write(input sfr_pkg::cfg_reg_t idx, input logic [63:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            sfr_pkg::REG_PATTERN_BYTES:      find_bytes  = value;
            sfr_pkg::REG_PATTERN_LENGTH:     find_len    = value[3:0];
            sfr_pkg::REG_REPLACEMENT_BYTES:  subst_bytes = value;
            sfr_pkg::REG_REPLACEMENT_LENGTH: subst_len   = value[3:0];
            sfr_pkg::REG_REPLACE_ALL_MODE:   all_mode    = value[0];
            default: ;
        endcase
    endtask

    task automatic apply_config(input logic [63:0] pat, input logic [3:0] plen,
                                input logic [63:0] rep, input logic [3:0] rlen,
                                input logic mode);
        cfg_write(sfr_pkg::REG_PATTERN_BYTES, pat);
        cfg_write(sfr_pkg::REG_PATTERN_LENGTH, 64'(plen));
        cfg_write(sfr_pkg::REG_REPLACEMENT_BYTES, rep);
        cfg_write(sfr_pkg::REG_REPLACEMENT_LENGTH, 64'(rlen));
        cfg_write(sfr_pkg::REG_REPLACE_ALL_MODE, 64'(mode));
        cfg_valid <= 1'b0;
    endtask

    // reset settings: single zero byte deleted, deleted final byte gives an empty end
    task automatic test_reset_defaults();
        send_byte(8'h41, 1'b0);
        send_byte(8'h00, 1'b1);
    endtask

    // every occurrence replaced, expansion to three bytes
    task automatic test_replace_all();
        wait_idle();
        apply_config(64'h6261, 4'd2, 64'h5A5958, 4'd3, 1'b1);
        send_string("abab");
    endtask

    // only the first occurrence per text, next text starts fresh
    task automatic test_first_only();
        wait_idle();
        apply_config(64'h6261, 4'd2, 64'h5A, 4'd1, 1'b0);
        send_string("abab");
        send_string("ab");
    endtask

    // lengths above the limit, length zero, byte extremes, eight beats from one byte
    task automatic test_length_limits();
        int i;
        wait_idle();
        apply_config(64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 64'h00FF_8001_7F10_2040, 4'd15, 1'b1);
        for (i = 0; i < 8; i++)
            send_byte(8'hFF, i == 7);
        wait_idle();
        apply_config(64'h0, 4'd0, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 1'b0);
        send_byte(8'h00, 1'b1);
    endtask

    // pattern shortened while the window holds more bytes than the new pattern
    task automatic test_pattern_shortened();
        wait_idle();
        apply_config(64'h636261, 4'd3, 64'h5A, 4'd1, 1'b1);
        send_byte(8'h77, 1'b0);
        send_byte(8'h78, 1'b0);
        send_byte(8'h79, 1'b0);
        wait_idle();
        apply_config(64'h71, 4'd1, 64'h5A, 4'd1, 1'b1);
        send_byte(8'h71, 1'b1);
    endtask

    // random settings biased toward short patterns and frequent matches
    task automatic random_config();
        logic [63:0] pat;
        logic [63:0] rep;
        logic [3:0]  plen;
        logic [3:0]  rlen;
        int          i;
        int          pick;
        for (i = 0; i < 8; i++)
            if ($urandom_range(0, 1) == 1)
                pat[8*i +: 8] = 8'($urandom_range(0, 255));
            else
                pat[8*i +: 8] = ($urandom_range(0, 1) == 1) ? 8'h61 : 8'h62;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            pat = '0;
        else if (pick == 1)
            pat = '1;
        rep = {$urandom(), $urandom()};
        pick = $urandom_range(0, 9);
        if (pick == 0)
            plen = 4'd0;
        else if (pick == 1)
            plen = 4'($urandom_range(9, 15));
        else if (pick < 6)
            plen = 4'($urandom_range(1, 3));
        else
            plen = 4'($urandom_range(1, 8));
        pick = $urandom_range(0, 9);
        if (pick < 2)
            rlen = 4'd0;
        else if (pick == 2)
            rlen = 4'($urandom_range(8, 15));
        else
            rlen = 4'($urandom_range(1, 8));
        apply_config(pat, plen, rep, rlen, 1'($urandom_range(0, 1)));
    endtask

    // one text built from pattern copies, partial prefixes and loose bytes
    task automatic send_random_text(output int n_sent);
        logic [7:0] chars[$];
        int         len;
        int         plen;
        int         k;
        int         j;
        int         part;
        int         cut;
        plen = find_len_used();
        len = $urandom_range(1, 24);
        while (chars.size() < len)
        begin
            k = $urandom_range(0, 99);
            if (k < 30)
            begin
                for (j = 0; j < plen; j++)
                    chars.push_back(find_bytes[8*j +: 8]);
            end
            else if (k < 45)
            begin
                part = $urandom_range(1, plen);
                for (j = 0; j < part; j++)
                    chars.push_back(find_bytes[8*j +: 8]);
            end
            else if (k < 75)
            begin
                j = $urandom_range(0, plen - 1);
                chars.push_back(find_bytes[8*j +: 8]);
            end
            else
                chars.push_back(8'($urandom_range(0, 255)));
        end
        // now and then the settings change in the middle of a text
        cut = -1;
        if (chars.size() > 1 && $urandom_range(0, 99) < 8)
            cut = $urandom_range(1, chars.size() - 1);
        for (j = 0; j < chars.size(); j++)
        begin
            if (j == cut)
            begin
                wait_idle();
                random_config();
            end
            send_byte(chars[j], j == chars.size() - 1);
        end
        n_sent = chars.size();
    endtask

    // random texts under three idle profiles
    task automatic test_random_texts();
        int phase;
        int sent;
        int n;
        for (phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 31 : (phase == 1) ? 45 : 0;
            recv_idle_pct = (phase == 0) ? 45 : (phase == 1) ? 31 : 0;
            sent = 0;
            while (sent < RANDOM_ITEMS / 3)
            begin
                if ($urandom_range(0, 99) < 30)
                begin
                    wait_idle();
                    random_config();
                end
                send_random_text(n);
                sent += n;
            end
        end
    endtask

    // reset and test sequence
    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_replace_all();
        test_first_only();
        test_length_limits();
        test_pattern_shortened();
        test_random_texts();
        wait_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0 && rewritten_beats.size() == 0)
            $display("stream_find_replace_top_tb: clean");
        else
            $display("stream_find_replace_top_tb: errors");
        $finish;
    end

endmodule
